### sv/mrdo_pkg.sv
// Package for the message ring with drop-oldest overflow.
// Sizes, types, transaction structs and address helpers; no dependencies.
`default_nettype none

package mrdo_pkg;

	// Ring geometry
	localparam int SLOTS     = 16;
	localparam int MSG_BYTES = 32;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int LEN_W     = $clog2(MSG_BYTES);
	localparam int PAY_DEPTH = SLOTS * MSG_BYTES;
	localparam int PAY_AW    = $clog2(PAY_DEPTH);
	localparam int MAX_LEN   = MSG_BYTES - 1;

	// Operation codes of an input transaction
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [PAY_AW-1:0] pay_addr_t;
	typedef logic [7:0]        byte_t;

	// Write requests from the push side into the stores
	typedef struct packed {
		logic      pay_we;
		pay_addr_t pay_addr;
		byte_t     pay_data;
		logic      len_we;
		slot_t     len_addr;
		len_t      len_data;
	} wr_req_t;

	// Read requests from the pop side into the stores
	typedef struct packed {
		logic      len_re;
		slot_t     len_addr;
		logic      pay_re;
		pay_addr_t pay_addr;
	} rd_req_t;

	// Ring status seen by the pop side
	typedef struct packed {
		logic  empty;
		slot_t slot;
		logic  pending;
	} pop_info_t;

	// Pop sequencer states
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} pop_state_t;

	// Slot index plus one, wrapping at the ring size
	function automatic slot_t next_slot(slot_t s);
		return (s == slot_t'(SLOTS - 1)) ? '0 : s + slot_t'(1);
	endfunction

	// Flat payload address of byte i in slot s
	function automatic pay_addr_t pay_addr(slot_t s, len_t i);
		return pay_addr_t'(s) * pay_addr_t'(MSG_BYTES) + pay_addr_t'(i);
	endfunction

endpackage

`default_nettype wire

### sv/mrdo_store.sv
// Payload and length memories of the message ring.
// Synchronous write, registered read; depends on mrdo_pkg.
`default_nettype none

module mrdo_store (
	input  wire logic             clk,
	input  wire mrdo_pkg::wr_req_t wr,
	input  wire mrdo_pkg::rd_req_t rd,
	output mrdo_pkg::len_t        len_rd,
	output mrdo_pkg::byte_t       pay_rd
);

	mrdo_pkg::byte_t pay_mem [mrdo_pkg::PAY_DEPTH];
	mrdo_pkg::len_t  len_mem [mrdo_pkg::SLOTS];
	mrdo_pkg::byte_t pay_rd_q;
	mrdo_pkg::len_t  len_rd_q;

	// Payload bytes, one write and one read port
	always_ff @(posedge clk) begin
		if (wr.pay_we) begin
			pay_mem[wr.pay_addr] <= wr.pay_data;
		end
		if (rd.pay_re) begin
			pay_rd_q <= pay_mem[rd.pay_addr];
		end
	end

	// Message lengths; read data holds until the next read
	always_ff @(posedge clk) begin
		if (wr.len_we) begin
			len_mem[wr.len_addr] <= wr.len_data;
		end
		if (rd.len_re) begin
			len_rd_q <= len_mem[rd.len_addr];
		end
	end

	assign pay_rd = pay_rd_q;
	assign len_rd = len_rd_q;

endmodule

`default_nettype wire

### sv/mrdo_ptrs.sv
// Ring pointers and push path of the message ring.
// Holds write/read slot and byte count; depends on mrdo_pkg.
`default_nettype none

module mrdo_ptrs (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push_fire,
	input  wire logic                pop_fire,
	input  wire mrdo_pkg::byte_t     data_byte,
	input  wire logic                byte_present,
	input  wire logic                end_of_message,
	output mrdo_pkg::wr_req_t        wr,
	output mrdo_pkg::pop_info_t      info
);

	mrdo_pkg::slot_t write_slot_q;
	mrdo_pkg::slot_t read_slot_q;
	mrdo_pkg::len_t  bytes_taken_q;
	logic            take_byte;
	mrdo_pkg::len_t  len_after;
	mrdo_pkg::slot_t ws_next;

	// Byte is stored only while the slot has room; extra bytes are dropped
	assign take_byte = byte_present && (bytes_taken_q != mrdo_pkg::len_t'(mrdo_pkg::MAX_LEN));
	assign len_after = take_byte ? bytes_taken_q + mrdo_pkg::len_t'(1) : bytes_taken_q;
	assign ws_next   = mrdo_pkg::next_slot(write_slot_q);

	// Store writes for a push transaction
	always_comb begin
		wr.pay_we   = push_fire && take_byte;
		wr.pay_addr = mrdo_pkg::pay_addr(write_slot_q, bytes_taken_q);
		wr.pay_data = data_byte;
		wr.len_we   = push_fire && end_of_message;
		wr.len_addr = write_slot_q;
		wr.len_data = len_after;
	end

	// Status for the pop side
	always_comb begin
		info.empty   = (write_slot_q == read_slot_q);
		info.slot    = read_slot_q;
		info.pending = (mrdo_pkg::next_slot(read_slot_q) != write_slot_q);
	end

	// Pointer update: commit advances write, overrun or pop advances read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q  <= '0;
			read_slot_q   <= '0;
			bytes_taken_q <= '0;
		end else if (push_fire) begin
			if (end_of_message) begin
				bytes_taken_q <= '0;
				write_slot_q  <= ws_next;
				if (ws_next == read_slot_q) begin
					read_slot_q <= mrdo_pkg::next_slot(read_slot_q);
				end
			end else begin
				bytes_taken_q <= len_after;
			end
		end else if (pop_fire && !info.empty) begin
			read_slot_q <= mrdo_pkg::next_slot(read_slot_q);
		end
	end

endmodule

`default_nettype wire

### sv/mrdo_pop.sv
// Pop sequencer of the message ring: reads a slot and streams its bytes.
// Drives store reads and the result registers; depends on mrdo_pkg.
`default_nettype none

module mrdo_pop (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                pop_fire,
	input  wire mrdo_pkg::pop_info_t info,
	input  wire mrdo_pkg::len_t      len_rd,
	input  wire mrdo_pkg::byte_t     pay_rd,
	output mrdo_pkg::rd_req_t        rd,
	output logic                     busy,
	output logic                     strobe,
	output mrdo_pkg::byte_t          out_byte,
	output logic                     out_last,
	output mrdo_pkg::len_t           msg_length,
	output logic                     was_empty,
	output logic                     still_pending
);

	mrdo_pkg::pop_state_t state_q;
	mrdo_pkg::slot_t      slot_q;
	mrdo_pkg::len_t       idx_q;
	logic                 pending_q;
	logic                 strobe_q;
	mrdo_pkg::byte_t      byte_q;
	logic                 last_q;
	mrdo_pkg::len_t       length_q;
	logic                 empty_q;
	logic                 still_q;
	logic                 run_last;
	logic                 start_read;

	assign busy       = (state_q == mrdo_pkg::ST_RUN);
	assign start_read = pop_fire && !info.empty;
	assign run_last   = (len_rd == '0) || (idx_q == len_rd - mrdo_pkg::len_t'(1));

	// Store reads: length and first byte on accept, then the next byte each cycle
	always_comb begin
		rd.len_re   = 1'b0;
		rd.len_addr = info.slot;
		rd.pay_re   = 1'b0;
		rd.pay_addr = mrdo_pkg::pay_addr(info.slot, '0);
		unique case (state_q)
			mrdo_pkg::ST_IDLE: begin
				rd.len_re = start_read;
				rd.pay_re = start_read;
			end
			mrdo_pkg::ST_RUN: begin
				rd.pay_re   = 1'b1;
				rd.pay_addr = mrdo_pkg::pay_addr(slot_q, idx_q + mrdo_pkg::len_t'(1));
			end
			default: begin
				rd.len_re = 1'b0;
				rd.pay_re = 1'b0;
			end
		endcase
	end

	// Sequencer control and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mrdo_pkg::ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				mrdo_pkg::ST_IDLE: begin
					if (pop_fire) begin
						strobe_q <= info.empty;
						if (!info.empty) begin
							state_q <= mrdo_pkg::ST_RUN;
						end
					end
				end
				mrdo_pkg::ST_RUN: begin
					strobe_q <= 1'b1;
					if (run_last) begin
						state_q <= mrdo_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= mrdo_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Result payload and stream position
	always_ff @(posedge clk) begin
		if (state_q == mrdo_pkg::ST_RUN) begin
			byte_q   <= (len_rd == '0) ? '0 : pay_rd;
			last_q   <= run_last;
			length_q <= len_rd;
			empty_q  <= 1'b0;
			still_q  <= pending_q;
			idx_q    <= idx_q + mrdo_pkg::len_t'(1);
		end else if (pop_fire) begin
			slot_q    <= info.slot;
			idx_q     <= '0;
			pending_q <= info.pending;
			// empty ring: single marked transaction
			byte_q    <= '0;
			last_q    <= 1'b1;
			length_q  <= '0;
			empty_q   <= 1'b1;
			still_q   <= 1'b0;
		end
	end

	assign strobe        = strobe_q;
	assign out_byte      = byte_q;
	assign out_last      = last_q;
	assign msg_length    = length_q;
	assign was_empty     = empty_q;
	assign still_pending = still_q;

endmodule

`default_nettype wire

### sv/message_ring_drop_oldest_unit.sv
// Top level of the message ring with drop-oldest overflow.
// Instantiates mrdo_ptrs, mrdo_store and mrdo_pop; depends on mrdo_pkg.
//
// A push transaction (operation 0) keeps busy low, so bytes may stream in
// on every clock. A pop transaction (operation 1) on an
// empty ring returns its single result in the next cycle without raising
// busy. A pop of a stored message raises busy while its bytes are read, one
// result per byte and one even for an empty message, through the single read
// port of the payload memory; the first result passes the state register and
// then the strobe register, the rest follow on consecutive cycles, each for
// exactly one cycle with strobe high, and the receiver cannot hold them off.
// The next transaction may be started in the cycle after busy falls. At most
// SLOTS-1 messages are held; a commit into a full ring discards the oldest one.
`default_nettype none

module message_ring_drop_oldest_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic                operation,
	input  wire mrdo_pkg::byte_t     data_byte,
	input  wire logic                byte_present,
	input  wire logic                end_of_message,
	output logic                     strobe,
	output mrdo_pkg::byte_t          out_byte,
	output logic                     out_last,
	output mrdo_pkg::len_t           msg_length,
	output logic                     was_empty,
	output logic                     still_pending
);

	logic                accept;
	logic                push_fire;
	logic                pop_fire;
	mrdo_pkg::wr_req_t   wr;
	mrdo_pkg::rd_req_t   rd;
	mrdo_pkg::pop_info_t info;
	mrdo_pkg::len_t      len_rd;
	mrdo_pkg::byte_t     pay_rd;

	// Transaction decode
	assign accept    = start && !busy;
	assign push_fire = accept && (operation == mrdo_pkg::OP_PUSH);
	assign pop_fire  = accept && (operation == mrdo_pkg::OP_POP);

	mrdo_ptrs u_ptrs (
		.clk            (clk),
		.arst_n         (arst_n),
		.push_fire      (push_fire),
		.pop_fire       (pop_fire),
		.data_byte      (data_byte),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.wr             (wr),
		.info           (info)
	);

	mrdo_store u_store (
		.clk    (clk),
		.wr     (wr),
		.rd     (rd),
		.len_rd (len_rd),
		.pay_rd (pay_rd)
	);

	mrdo_pop u_pop (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_fire      (pop_fire),
		.info          (info),
		.len_rd        (len_rd),
		.pay_rd        (pay_rd),
		.rd            (rd),
		.busy          (busy),
		.strobe        (strobe),
		.out_byte      (out_byte),
		.out_last      (out_last),
		.msg_length    (msg_length),
		.was_empty     (was_empty),
		.still_pending (still_pending)
	);

	// Busy ends only with the final transaction of a pop
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && out_last)
		else $error("busy fell without a final result");

	// A result that is not the last one only appears mid-stream
	a_mid_stream: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !out_last |-> busy && msg_length != '0)
		else $error("non-final result outside a stream");

	// Empty-ring result carries the fixed marking
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && was_empty |-> out_last && msg_length == '0 && !still_pending)
		else $error("malformed empty-ring result");

	// An accepted pop has a result strobed or a stream busy in the cycle after acceptance
	a_first_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop_fire |=> strobe || busy)
		else $error("pop accepted without a result in progress");

endmodule

`default_nettype wire

### tb/sv/message_ring_drop_oldest_unit_tb.sv
// Testbench for message_ring_drop_oldest_unit: directed and random push/pop traffic
// checked against an in-bench model of the message ring.
// Depends on mrdo_pkg and the message_ring_drop_oldest_unit RTL.

module message_ring_drop_oldest_unit_tb;

	import mrdo_pkg::*;

	localparam int   QUIET_LIMIT = 2000;
	localparam int   DRAIN_WAIT  = 40;

	// One popped byte as the block should present it
	typedef struct packed {
		byte_t data;
		logic  last;
		len_t  len;
		logic  empty;
		logic  pending;
	} pop_beat_t;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	logic  operation;
	byte_t data_byte;
	logic  byte_present;
	logic  end_of_message;
	logic  strobe;
	byte_t out_byte;
	logic  out_last;
	len_t  msg_length;
	logic  was_empty;
	logic  still_pending;

	// Ring model state
	byte_t ring_pay [PAY_DEPTH];
	len_t  ring_len [SLOTS];
	int    ring_wr;
	int    ring_rd;
	int    ring_fill;
	bit    ring_over;

	pop_beat_t due_beats[$];
	pop_beat_t beat_exp;

	int idle_pct;
	int quiet_cycles = 0;
	int errors = 0;
	int n_push = 0, n_commit = 0, n_trunc = 0, n_drop = 0;
	int n_pop = 0, n_pop_empty = 0, n_beats = 0;

	message_ring_drop_oldest_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.data_byte      (data_byte),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.strobe         (strobe),
		.out_byte       (out_byte),
		.out_last       (out_last),
		.msg_length     (msg_length),
		.was_empty      (was_empty),
		.still_pending  (still_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Queue one expected popped byte
	function automatic void queue_beat(byte_t b, logic last, len_t len, logic empty,
			logic pending);
		pop_beat_t beat;
		beat.data    = b;
		beat.last    = last;
		beat.len     = len;
		beat.empty   = empty;
		beat.pending = pending;
		due_beats.push_back(beat);
	endfunction

	// Advance the ring model by one accepted transaction
	function automatic void track_ring(logic op, byte_t b, logic present, logic eom);
		int   rs;
		int   len;
		int   i;
		logic more;
		if (op == OP_PUSH) begin
			n_push++;
			if (present) begin
				if (ring_fill < MAX_LEN) begin
					ring_pay[ring_wr * MSG_BYTES + ring_fill] = b;
					ring_fill++;
				end else
					ring_over = 1'b1;
			end
			if (eom) begin
				ring_len[ring_wr] = len_t'(ring_fill);
				if (ring_over)
					n_trunc++;
				ring_fill = 0;
				ring_over = 1'b0;
				ring_wr   = (ring_wr + 1) % SLOTS;
				n_commit++;
				// full ring: oldest message gives way
				if (ring_wr == ring_rd) begin
					ring_rd = (ring_rd + 1) % SLOTS;
					n_drop++;
				end
			end
		end else begin
			n_pop++;
			if (ring_wr == ring_rd) begin
				n_pop_empty++;
				queue_beat(8'h00, 1'b1, '0, 1'b1, 1'b0);
			end else begin
				rs      = ring_rd;
				len     = ring_len[rs];
				ring_rd = (rs + 1) % SLOTS;
				more    = (ring_wr != ring_rd);
				if (len == 0)
					queue_beat(8'h00, 1'b1, '0, 1'b0, more);
				else
					for (i = 0; i < len; i++)
						queue_beat(ring_pay[rs * MSG_BYTES + i], i == len - 1,
							len_t'(len), 1'b0, more);
			end
		end
	endfunction

	function automatic int ring_count();
		return (ring_wr - ring_rd + SLOTS) % SLOTS;
	endfunction

	// Drive one transaction, wait for the handshake, then update the model
	task automatic send_item(input logic op, input byte_t b, input logic present,
			input logic eom);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		start          <= 1'b1;
		operation      <= op;
		data_byte      <= b;
		byte_present   <= present;
		end_of_message <= eom;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		track_ring(op, b, present, eom);
	endtask

	// Pop with junk in the ignored fields
	task automatic pop_message();
		send_item(OP_POP, byte_t'($urandom), 1'($urandom), 1'($urandom));
	endtask

	// Push a whole message of random bytes; commit on the last byte or on its own
	task automatic push_message(input int n_bytes);
		int i;
		bit split;
		split = (n_bytes == 0) || ($urandom_range(3) == 0);
		for (i = 0; i < n_bytes; i++) begin
			if ($urandom_range(15) == 0)
				send_item(OP_PUSH, byte_t'($urandom), 1'b0, 1'b0);
			send_item(OP_PUSH, byte_t'($urandom), 1'b1, !split && (i == n_bytes - 1));
		end
		if (split)
			send_item(OP_PUSH, byte_t'($urandom), 1'b0, 1'b1);
	endtask

	// Pops straight after reset find nothing
	task automatic test_empty_pop();
		send_item(OP_POP, 8'hFF, 1'b1, 1'b1);
		send_item(OP_POP, 8'h00, 1'b0, 1'b0);
	endtask

	// Byte extremes, plus an item that carries neither byte nor end mark
	task automatic test_byte_extremes();
		send_item(OP_PUSH, 8'h00, 1'b1, 1'b0);
		send_item(OP_PUSH, 8'h77, 1'b0, 1'b0);
		send_item(OP_PUSH, 8'hFF, 1'b1, 1'b1);
		pop_message();
	endtask

	// A commit with no bytes stores an empty message
	task automatic test_empty_message();
		send_item(OP_PUSH, 8'hAA, 1'b0, 1'b1);
		push_message(1);
		pop_message();
		pop_message();
		pop_message();
	endtask

	// A pop in the middle of a push leaves the unfinished message alone
	task automatic test_pop_mid_push();
		send_item(OP_PUSH, 8'hA5, 1'b1, 1'b0);
		pop_message();
		send_item(OP_PUSH, 8'h5A, 1'b1, 1'b1);
		send_item(OP_PUSH, 8'h3C, 1'b1, 1'b0);
		pop_message();
		send_item(OP_PUSH, 8'hC3, 1'b1, 1'b1);
		pop_message();
		pop_message();
	endtask

	// Overfill the ring so that commits discard the oldest, then drain it
	task automatic test_ring_overflow();
		int i;
		int n_msgs;
		n_msgs = $urandom_range(SLOTS + 1, SLOTS + 4);
		for (i = 0; i < n_msgs; i++)
			push_message($urandom_range(0, 2));
		while (ring_count() != 0)
			pop_message();
		pop_message();
	endtask

	// Messages at and beyond the slot limit
	task automatic test_truncation();
		push_message($urandom_range(MAX_LEN, MAX_LEN + 5));
		pop_message();
	endtask

	// Free mix of pushes, pops and empty items
	task automatic test_mixed_traffic(input int n_items);
		int done;
		int pick;
		done = 0;
		while (done < n_items) begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				pop_message();
				done++;
			end else if (pick < 25)
				send_item(OP_PUSH, byte_t'($urandom), 1'b0, 1'b0);
			else begin
				send_item(OP_PUSH, byte_t'($urandom), $urandom_range(9) != 0,
					$urandom_range(5) == 0);
				done++;
			end
		end
	endtask

	// Result checking
	function automatic void check_field(string field, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, field, exp_v, act_v);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (due_beats.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, got byte %0h last %0b len %0d",
					$time, out_byte, out_last, msg_length);
			end else begin
				beat_exp = due_beats.pop_front();
				n_beats++;
				// byte carries no meaning on an empty-ring pop
				if (!beat_exp.empty)
					check_field("out_byte", beat_exp.data, out_byte);
				check_field("out_last", beat_exp.last, out_last);
				check_field("msg_length", beat_exp.len, msg_length);
				check_field("was_empty", beat_exp.empty, was_empty);
				check_field("still_pending", beat_exp.pending, still_pending);
			end
		end
	end

	// Watchdog on cycles with no transaction in either direction
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe)
			quiet_cycles = 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("message_ring_drop_oldest_unit: mismatch");
			$finish;
		end else
			quiet_cycles++;
	end

	// Main sequence
	initial begin
		int idle_plan[3];
		int p;
		idle_plan = '{33, 59, 0};
		arst_n         <= 1'b0;
		start          <= 1'b0;
		operation      <= OP_PUSH;
		data_byte      <= '0;
		byte_present   <= 1'b0;
		end_of_message <= 1'b0;
		ring_wr   = 0;
		ring_rd   = 0;
		ring_fill = 0;
		ring_over = 1'b0;
		idle_pct  = idle_plan[0];
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_pop();
		test_byte_extremes();
		test_empty_message();
		test_pop_mid_push();
		for (p = 0; p < 3; p++) begin
			idle_pct = idle_plan[p];
			test_ring_overflow();
			test_truncation();
			test_mixed_traffic(30);
		end
		start <= 1'b0;

		while (due_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Covered %0d pushes, %0d commits (%0d truncated, %0d displaced the oldest),",
			n_push, n_commit, n_trunc, n_drop);
		$display("%0d pops (%0d on an empty ring), %0d popped bytes checked, %0d errors.",
			n_pop, n_pop_empty, n_beats, errors);
		if (errors == 0)
			$display("message_ring_drop_oldest_unit: match");
		else
			$display("message_ring_drop_oldest_unit: mismatch");
		$finish;
	end

endmodule

### sim.f
sv/mrdo_pkg.sv
sv/mrdo_store.sv
sv/mrdo_ptrs.sv
sv/mrdo_pop.sv
sv/message_ring_drop_oldest_unit.sv
tb/sv/message_ring_drop_oldest_unit_tb.sv
